// File: hw/rtl/ewah_pkg.sv
// ----------------------------------------------------------------------------
// EWAH word run encoder package
// Shared types, constants and the saturating counter step.
// ----------------------------------------------------------------------------
package ewah_pkg;

   localparam int MAX_WORDS = 4096;
   localparam int CNT_W     = 13;
   localparam int WORD_W    = 32;
   localparam int REF_W     = 4;
   localparam int FIELD_MAX = (1 << CNT_W) - 1;

   // Counts stop at the word limit, or at the field maximum if that is lower.
   localparam logic [CNT_W-1:0] COUNT_CAP =
      (MAX_WORDS < FIELD_MAX) ? CNT_W'(MAX_WORDS) : CNT_W'(FIELD_MAX);

   localparam logic KIND_LITERAL = 1'b0;
   localparam logic KIND_HEADER  = 1'b1;

   typedef struct packed {
      logic              clean;
      logic [REF_W-1:0]  ref_value;
   } class_type;

   typedef struct packed {
      logic              kind;
      logic [WORD_W-1:0] literal;
      logic [REF_W-1:0]  ref_value;
      logic [CNT_W-1:0]  clean_count;
      logic [CNT_W-1:0]  dirty_count;
      logic [CNT_W-1:0]  group_total;
      logic              record_end;
      logic              overflow;
   } result_type;

   // Returns {saturated, next value}.
   function automatic logic [CNT_W:0] sat_inc(input logic [CNT_W-1:0] v);
      logic [CNT_W:0] r;
      if (v >= COUNT_CAP) begin
         r = {1'b1, COUNT_CAP};
      end else begin
         r = {1'b0, v + CNT_W'(1)};
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/ewah_classify.sv
// ----------------------------------------------------------------------------
// EWAH word classifier
// Decides whether a word is clean and extracts its reference value.
// ----------------------------------------------------------------------------
module ewah_classify
   import ewah_pkg::*;
(
   input  logic              nibble_mode,
   input  logic [WORD_W-1:0] word,
   output class_type         cls
);

   always_comb begin
      if (nibble_mode) begin
         cls.ref_value = word[REF_W-1:0];
         cls.clean     = (word == {(WORD_W / REF_W){word[REF_W-1:0]}});
      end else begin
         cls.ref_value = {{(REF_W - 1){1'b0}}, word[0]};
         cls.clean     = (word == '0) || (&word);
      end
   end

endmodule

// File: hw/rtl/ewah_group.sv
// ----------------------------------------------------------------------------
// EWAH group tracker
// Holds the open group and forms the literal and header words of one item.
// ----------------------------------------------------------------------------
module ewah_group
   import ewah_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  class_type         cls,
   input  logic [WORD_W-1:0] word,
   input  logic              last_word,
   output logic [1:0]        num_results,
   output result_type        res_a,
   output result_type        res_b
);

   logic              open_ff,   open_in;
   logic [CNT_W-1:0]  clean_ff,  clean_in;
   logic [CNT_W-1:0]  dirty_ff,  dirty_in;
   logic [REF_W-1:0]  ref_ff,    ref_in;
   logic [CNT_W-1:0]  groups_ff, groups_in;
   logic              sat_ff,    sat_in;

   logic [CNT_W:0]    inc_clean;
   logic [CNT_W:0]    inc_dirty;
   logic [CNT_W:0]    inc_groups;
   logic [CNT_W:0]    inc_total;
   logic              first_valid;
   result_type        first_res;
   result_type        final_res;

   always_comb begin
      open_in    = open_ff;
      clean_in   = clean_ff;
      dirty_in   = dirty_ff;
      ref_in     = ref_ff;
      groups_in  = groups_ff;
      sat_in     = sat_ff;
      first_valid = 1'b0;
      first_res   = '0;

      inc_clean  = sat_inc(clean_ff);
      inc_dirty  = sat_inc(open_ff ? dirty_ff : '0);
      inc_groups = sat_inc(groups_ff);

      if (!cls.clean) begin
         // Dirty words pass through as literals; they open a group with no
         // clean run when none is open.
         open_in  = 1'b1;
         if (!open_ff) begin
            clean_in = '0;
            ref_in   = '0;
         end
         dirty_in = inc_dirty[CNT_W-1:0];
         sat_in   = (open_ff & sat_ff) | inc_dirty[CNT_W];
         first_valid       = 1'b1;
         first_res.kind    = KIND_LITERAL;
         first_res.literal = word;
      end else if (!open_ff || dirty_ff != '0 || ref_ff != cls.ref_value) begin
         if (open_ff) begin
            // The open group closes and its header follows its literals.
            first_valid           = 1'b1;
            first_res.kind        = KIND_HEADER;
            first_res.ref_value   = ref_ff;
            first_res.clean_count = clean_ff;
            first_res.dirty_count = dirty_ff;
            first_res.overflow    = sat_ff;
            groups_in             = inc_groups[CNT_W-1:0];
         end
         open_in  = 1'b1;
         clean_in = CNT_W'(1);
         dirty_in = '0;
         ref_in   = cls.ref_value;
         sat_in   = 1'b0;
      end else begin
         clean_in = inc_clean[CNT_W-1:0];
         sat_in   = sat_ff | inc_clean[CNT_W];
      end

      inc_total = sat_inc(groups_in);
      final_res             = '0;
      final_res.kind        = KIND_HEADER;
      final_res.ref_value   = ref_in;
      final_res.clean_count = clean_in;
      final_res.dirty_count = dirty_in;
      final_res.group_total = inc_total[CNT_W-1:0];
      final_res.record_end  = 1'b1;
      final_res.overflow    = sat_in | inc_total[CNT_W];

      if (last_word) begin
         // The record ends; the next word starts from the reset state.
         open_in   = 1'b0;
         clean_in  = '0;
         dirty_in  = '0;
         ref_in    = '0;
         groups_in = '0;
         sat_in    = 1'b0;
      end

      num_results = {1'b0, first_valid} + {1'b0, last_word};
      res_a       = first_valid ? first_res : final_res;
      res_b       = final_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= 1'b0;
         clean_ff  <= '0;
         dirty_ff  <= '0;
         ref_ff    <= '0;
         groups_ff <= '0;
         sat_ff    <= 1'b0;
      end else if (advance) begin
         open_ff   <= open_in;
         clean_ff  <= clean_in;
         dirty_ff  <= dirty_in;
         ref_ff    <= ref_in;
         groups_ff <= groups_in;
         sat_ff    <= sat_in;
      end
   end

endmodule

// File: hw/rtl/ewah_obuf.sv
// ----------------------------------------------------------------------------
// EWAH output buffer
// Two-entry result register that lets one item deliver up to two words.
// ----------------------------------------------------------------------------
module ewah_obuf
   import ewah_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [1:0] num_results,
   input  result_type res_a,
   input  result_type res_b,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output result_type head,
   output logic       room
);

   logic [1:0] count_ff, count_in;
   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign head      = slot0_ff;
   assign pop       = rsp_valid & ~rsp_stall;
   // The buffer is empty after this edge's delivery.
   assign room      = (count_ff == 2'd0) || (count_ff == 2'd1 && pop);

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (push) begin
         count_in = num_results;
         slot0_in = res_a;
         slot1_in = res_b;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// File: hw/rtl/ewah_word_run_encoder_core.sv
// ----------------------------------------------------------------------------
// EWAH word run encoder core
// Turns a record of 32-bit bitmap words into literal words and group headers.
// ----------------------------------------------------------------------------
// A word is accepted into an input register and, once the result side can
// take what it produces, is classified combinationally and folded into the
// open group. Dirty words come out as literals, a clean word with a new
// reference or after literals closes the group with a header, and the last
// word of a record adds the final header with the group total. The block
// takes one word per cycle as long as each word yields at most one result
// word and the result side keeps up. A last word that is dirty or that
// closes a group yields two result words; the next word that yields a
// result then waits while the two-entry output buffer drains. A word that
// yields nothing, such as one that opens or extends a clean run, never
// waits. The mode register is sampled when a word is processed and should
// be written only while the block is idle.
// ----------------------------------------------------------------------------
module ewah_word_run_encoder_core
   import ewah_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              csr_write_enable,
   input  logic              csr_write_data,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [WORD_W-1:0] req_word,
   input  logic              req_last_word,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_kind,
   output logic [WORD_W-1:0] rsp_literal,
   output logic [REF_W-1:0]  rsp_ref_value,
   output logic [CNT_W-1:0]  rsp_clean_count,
   output logic [CNT_W-1:0]  rsp_dirty_count,
   output logic [CNT_W-1:0]  rsp_group_total,
   output logic              rsp_record_end,
   output logic              rsp_overflow
);

   logic              mode_ff;
   logic              in_valid_ff, in_valid_in;
   logic [WORD_W-1:0] in_word_ff;
   logic              in_last_ff;

   class_type         cls;
   logic [1:0]        num_results;
   result_type        res_a;
   result_type        res_b;
   result_type        head;
   logic              room;
   logic              advance;
   logic              accept;

   // The held word moves on when it produces nothing or when the output
   // buffer will be empty after this edge.
   assign advance   = in_valid_ff & ((num_results == 2'd0) | room);
   assign req_stall = in_valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_word;
         in_last_ff <= req_last_word;
      end
   end

   ewah_classify u_classify (
      .nibble_mode (mode_ff),
      .word        (in_word_ff),
      .cls         (cls)
   );

   ewah_group u_group (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .cls         (cls),
      .word        (in_word_ff),
      .last_word   (in_last_ff),
      .num_results (num_results),
      .res_a       (res_a),
      .res_b       (res_b)
   );

   ewah_obuf u_obuf (
      .clock       (clock),
      .reset       (reset),
      .push        (advance & (num_results != 2'd0)),
      .num_results (num_results),
      .res_a       (res_a),
      .res_b       (res_b),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .head        (head),
      .room        (room)
   );

   assign rsp_kind        = head.kind;
   assign rsp_literal     = head.literal;
   assign rsp_ref_value   = head.ref_value;
   assign rsp_clean_count = head.clean_count;
   assign rsp_dirty_count = head.dirty_count;
   assign rsp_group_total = head.group_total;
   assign rsp_record_end  = head.record_end;
   assign rsp_overflow    = head.overflow;

endmodule

// File: verif/ewah_word_run_encoder_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// EWAH word run encoder core testbench
// Streams records of bitmap words through the encoder under random idling on
// both channels, predicts every literal and group header, and checks each
// result word against that prediction.
// ----------------------------------------------------------------------------
module ewah_word_run_encoder_core_test
   import ewah_pkg::*;
();

   // The core holds a word in its input register before folding it, so a short
   // settle after the last result covers a word that folded silently into a run.
   localparam int SETTLE_CYCLES = 8;
   // The longest correct silence is a sender gap plus two stalled results.
   localparam int QUIET_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_WORDS   = 248;
   localparam int PHASE_COUNT   = 6;
   // Mode for each random phase, bit p for phase p.
   localparam logic [PHASE_COUNT-1:0] PHASE_MODES = 6'b101101;

   typedef enum logic {ROW_WORD, ROW_MODE} row_op_type;

   // One line of the directed table. A word row may repeat its word, and
   // with alt set every second copy has bit 0 flipped. A typed row carries
   // its single expected result; all other rows go through the predictor.
   typedef struct {
      row_op_type        op;
      logic [WORD_W-1:0] word;
      logic              last;
      int                reps;
      bit                alt;
      bit                typed;
      result_type        want;
   } stim_row_type;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic              csr_write_data   = 1'b0;
   logic              req_valid        = 1'b0;
   logic [WORD_W-1:0] req_word         = '0;
   logic              req_last_word    = 1'b0;
   logic              rsp_stall        = 1'b0;

   logic              req_stall;
   logic              rsp_valid;
   logic              rsp_kind;
   logic [WORD_W-1:0] rsp_literal;
   logic [REF_W-1:0]  rsp_ref_value;
   logic [CNT_W-1:0]  rsp_clean_count;
   logic [CNT_W-1:0]  rsp_dirty_count;
   logic [CNT_W-1:0]  rsp_group_total;
   logic              rsp_record_end;
   logic              rsp_overflow;

   // Predictor state: the open group of the current record and the mode
   // register as the block should see it.
   logic              mode_nibble   = 1'b0;
   logic              grp_open      = 1'b0;
   logic [CNT_W-1:0]  clean_run     = '0;
   logic [CNT_W-1:0]  dirty_run     = '0;
   logic [REF_W-1:0]  run_ref       = '0;
   logic [CNT_W-1:0]  closed_groups = '0;
   logic              sat_seen      = 1'b0;

   // Result words owed by the block, oldest first.
   result_type        encoded_due[$];

   // Sender side: the mode the stimulus believes is set, and the reference
   // that random clean runs keep reusing so that runs grow long.
   logic              cur_mode      = 1'b0;
   logic [REF_W-1:0]  held_nib      = '0;
   bit                idle_on       = 1'b1;

   // A typed expectation travels with its word like part of the payload.
   bit                typed_on      = 1'b0;
   result_type        typed_want    = '0;

   int                stall_left    = 0;
   int                quiet_cycles  = 0;
   int                fail_count    = 0;

   ewah_word_run_encoder_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .req_last_word    (req_last_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_literal      (rsp_literal),
      .rsp_ref_value    (rsp_ref_value),
      .rsp_clean_count  (rsp_clean_count),
      .rsp_dirty_count  (rsp_dirty_count),
      .rsp_group_total  (rsp_group_total),
      .rsp_record_end   (rsp_record_end),
      .rsp_overflow     (rsp_overflow)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic result_type enc(input logic k, input logic [WORD_W-1:0] lit,
                                      input logic [REF_W-1:0] rv,
                                      input logic [CNT_W-1:0] cc,
                                      input logic [CNT_W-1:0] dc,
                                      input logic [CNT_W-1:0] tot,
                                      input logic re, input logic ov);
      result_type r;
      r.kind        = k;
      r.literal     = lit;
      r.ref_value   = rv;
      r.clean_count = cc;
      r.dirty_count = dc;
      r.group_total = tot;
      r.record_end  = re;
      r.overflow    = ov;
      return r;
   endfunction

   function automatic string show(input result_type r);
      return $sformatf({"kind %0d literal %h ref %h clean %0d dirty %0d",
                        " total %0d end %0d ovf %0d"},
                       r.kind, r.literal, r.ref_value, r.clean_count, r.dirty_count,
                       r.group_total, r.record_end, r.overflow);
   endfunction

   // Counters stop at the cap; callers test the cap first to raise a flag.
   function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
      return (v >= COUNT_CAP) ? COUNT_CAP : v + 1'b1;
   endfunction

   function automatic void start_group(input logic [CNT_W-1:0] c, input logic [REF_W-1:0] rv);
      grp_open  = 1'b1;
      clean_run = c;
      dirty_run = '0;
      run_ref   = rv;
      sat_seen  = 1'b0;
   endfunction

   function automatic void clear_record();
      grp_open      = 1'b0;
      clean_run     = '0;
      dirty_run     = '0;
      run_ref       = '0;
      closed_groups = '0;
      sat_seen      = 1'b0;
   endfunction

   // Folds one accepted word into the open group and queues the literal or
   // header it releases, then the final header if the word ends the record.
   // Returns how many result words were queued.
   function automatic int encode_word(input logic [WORD_W-1:0] w, input logic lst);
      logic [REF_W-1:0] rv;
      logic             clean_word;
      logic             tot_sat;
      int               n;
      n = 0;
      if (mode_nibble) begin
         rv         = w[REF_W-1:0];
         clean_word = (w == {8{w[3:0]}});
      end else begin
         rv         = REF_W'(w[0]);
         clean_word = (w == '0) || (w == '1);
      end

      if (!clean_word) begin
         if (!grp_open) begin
            start_group('0, '0);
         end
         if (dirty_run >= COUNT_CAP) begin
            sat_seen = 1'b1;
         end
         dirty_run = count_up(dirty_run);
         encoded_due = {encoded_due, enc(KIND_LITERAL, w, '0, '0, '0, '0, 1'b0, 1'b0)};
         n++;
      end else if (!grp_open) begin
         start_group(CNT_W'(1), rv);
      end else if (dirty_run != 0 || run_ref != rv) begin
         // A clean word after literals, or with a new reference, closes
         // the group; the closed group's header goes out now.
         encoded_due = {encoded_due, enc(KIND_HEADER, '0, run_ref, clean_run, dirty_run,
                                         '0, 1'b0, sat_seen)};
         n++;
         closed_groups = count_up(closed_groups);
         start_group(CNT_W'(1), rv);
      end else begin
         if (clean_run >= COUNT_CAP) begin
            sat_seen = 1'b1;
         end
         clean_run = count_up(clean_run);
      end

      if (lst) begin
         tot_sat = (closed_groups >= COUNT_CAP);
         encoded_due = {encoded_due, enc(KIND_HEADER, '0, run_ref, clean_run, dirty_run,
                                         count_up(closed_groups), 1'b1,
                                         sat_seen | tot_sat)};
         n++;
         clear_record();
      end
      return n;
   endfunction

   function automatic int idle_draw();
      return idle_on ? int'($urandom_range(0, 19)) : 0;
   endfunction

   // Random words lean on clean runs of the current mode so that groups
   // grow and close often; others are all zeros or ones, near-clean or arbitrary.
   function automatic logic [WORD_W-1:0] random_word();
      int                pick;
      logic [WORD_W-1:0] base;
      logic [WORD_W-1:0] w;
      pick = $urandom_range(0, 9);
      if (pick == 4) begin
         held_nib = REF_W'($urandom());
      end
      base = cur_mode ? {8{held_nib}} : {32{held_nib[0]}};
      case (pick) inside
         [0:4]:   w = base;
         5:       w = $urandom_range(0, 1) ? '1 : '0;
         6:       w = base ^ (32'h1 << $urandom_range(0, 31));
         default: w = $urandom();
      endcase
      return w;
   endfunction

   function automatic stim_row_type plain(input logic [WORD_W-1:0] w, input logic lst,
                                          input int reps, input bit alt);
      stim_row_type r;
      r.op    = ROW_WORD;
      r.word  = w;
      r.last  = lst;
      r.reps  = reps;
      r.alt   = alt;
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   function automatic stim_row_type checked(input logic [WORD_W-1:0] w, input logic lst,
                                            input result_type want);
      stim_row_type r;
      r       = plain(w, lst, 1, 1'b0);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   function automatic stim_row_type mode_row(input logic v);
      stim_row_type r;
      r      = plain(WORD_W'(v), 1'b0, 1, 1'b0);
      r.op   = ROW_MODE;
      return r;
   endfunction

   // Offers one word after a random gap and returns at the edge where it
   // was taken. Valid is lowered only for a real gap, so back-to-back words
   // never see valid dropped and raised within one step.
   task automatic push_word(input logic [WORD_W-1:0] w, input logic lst,
                            input bit tflag, input result_type twant);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_word      <= w;
      req_last_word <= lst;
      typed_on      <= tflag;
      typed_want    <= twant;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Holds the sender back until every owed result word has come out, then
   // lets a word that only extended a run finish inside the block. The
   // first edge makes sure the word taken just before is already predicted.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (encoded_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The mode register is written only with the block idle. The open group
   // of a record survives the write, which is how mid-record mode changes
   // are exercised.
   task automatic write_mode(input logic v);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      cur_mode          = v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Receiver: after each accepted result word, stall for a random count.
   always @(posedge clock) begin : result_sink
      int d;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         d = idle_draw();
         stall_left <= d;
         rsp_stall  <= (d != 0);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end
   end

   // Everything is sampled at the clock edge: register writes and accepted
   // words feed the predictor, accepted results are checked in order.
   always @(posedge clock) begin : port_watch
      result_type seen;
      result_type want;
      int         n;
      if (reset) begin
         mode_nibble  = 1'b0;
         quiet_cycles = 0;
         clear_record();
      end else begin
         if (csr_write_enable) begin
            mode_nibble = csr_write_data;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (req_valid && !req_stall) begin
            n = encode_word(req_word, req_last_word);
            if (typed_on && n == 1) begin
               encoded_due[encoded_due.size() - 1] = typed_want;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            seen = enc(rsp_kind, rsp_literal, rsp_ref_value, rsp_clean_count,
                       rsp_dirty_count, rsp_group_total, rsp_record_end, rsp_overflow);
            if (encoded_due.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("unexpected result word: %s", show(seen));
               end
            end else begin
               want = encoded_due.pop_front();
               if (seen !== want) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("result mismatch\n  expected %s\n  actual   %s",
                              show(want), show(seen));
                  end
               end
            end
         end
      end
   end

   // Ends a hung run: nothing moved on either channel for too long.
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("ewah_word_run_encoder_core_test failed");
      $finish;
   end

   initial begin : stimulus
      stim_row_type rows[$];
      int           pause_at;

      // Directed table, starting in bit mode after reset.
      // Dirty word opens a group with no clean run.
      rows = {rows, checked(32'hDEADBEEF, 1'b0,
                            enc(KIND_LITERAL, 32'hDEADBEEF, 0, 0, 0, 0, 0, 0))};
      // A clean word after a literal closes that group.
      rows = {rows, checked(32'h00000000, 1'b0, enc(KIND_HEADER, 0, 0, 0, 1, 0, 0, 0))};
      rows = {rows, plain(32'h00000000, 1'b0, 1, 1'b0)};
      // All ones has reference 1, so the zero run closes.
      rows = {rows, checked(32'hFFFFFFFF, 1'b0, enc(KIND_HEADER, 0, 0, 2, 0, 0, 0, 0))};
      rows = {rows, checked(32'hFFFFFFFF, 1'b1, enc(KIND_HEADER, 0, 1, 2, 0, 3, 1, 0))};
      // Single dirty word forming a whole record.
      rows = {rows, plain(32'h00000001, 1'b1, 1, 1'b0)};
      rows = {rows, checked(32'hFFFFFFFF, 1'b1, enc(KIND_HEADER, 0, 1, 1, 0, 1, 1, 0))};
      rows = {rows, checked(32'h80000000, 1'b0,
                            enc(KIND_LITERAL, 32'h80000000, 0, 0, 0, 0, 0, 0))};
      rows = {rows, checked(32'h7FFFFFFF, 1'b0,
                            enc(KIND_LITERAL, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0))};
      // Last word that also closes a group: two result words.
      rows = {rows, plain(32'h00000000, 1'b1, 1, 1'b0)};
      // Mode change in the middle of a record; 0x11111111 then extends the
      // reference-1 run and all ones (nibble F) closes it.
      rows = {rows, plain(32'hFFFFFFFF, 1'b0, 1, 1'b0)};
      rows = {rows, mode_row(1'b1)};
      rows = {rows, plain(32'h11111111, 1'b0, 1, 1'b0)};
      rows = {rows, checked(32'hFFFFFFFF, 1'b0, enc(KIND_HEADER, 0, 1, 2, 0, 0, 0, 0))};
      rows = {rows, checked(32'h77777776, 1'b0,
                            enc(KIND_LITERAL, 32'h77777776, 0, 0, 0, 0, 0, 0))};
      rows = {rows, plain(32'h33333333, 1'b1, 1, 1'b0)};
      // A longer clean run ended by its own last word.
      rows = {rows, plain(32'h00000000, 1'b0, 20, 1'b0)};
      rows = {rows, checked(32'h00000000, 1'b1, enc(KIND_HEADER, 0, 0, 21, 0, 1, 1, 0))};
      // Alternating clean and dirty words close a group every other word.
      rows = {rows, mode_row(1'b0)};
      rows = {rows, plain(32'h00000000, 1'b0, 20, 1'b1)};
      rows = {rows, plain(32'hFFFFFFFF, 1'b1, 1, 1'b0)};
      rows = {rows, mode_row(1'b1)};
      rows = {rows, checked(32'hFFFFFFFF, 1'b1, enc(KIND_HEADER, 0, 15, 1, 0, 1, 1, 0))};
      rows = {rows, plain(32'hF0F0F0F0, 1'b1, 1, 1'b0)};

      // Synchronous reset held from time zero and released at an edge.
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].op == ROW_MODE) begin
            write_mode(rows[i].word[0]);
         end else begin
            for (int k = 0; k < rows[i].reps; k++) begin
               push_word(rows[i].word ^ WORD_W'(rows[i].alt && k[0]),
                         rows[i].last && (k == rows[i].reps - 1),
                         rows[i].typed, rows[i].want);
            end
         end
      end

      // Random phases, each under its own mode; records run across phase
      // boundaries, so some mode writes land inside an open record. One
      // phase runs without any idling, and each phase pauses once until
      // every owed result word has drained.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         idle_on = (p != 2);
         write_mode(PHASE_MODES[p]);
         pause_at = $urandom_range(20, PHASE_WORDS - 20);
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if (k == pause_at) begin
               settle();
            end
            push_word(random_word(), $urandom_range(0, 19) == 0, 1'b0, '0);
         end
      end

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ewah_word_run_encoder_core_test passed");
      end else begin
         $display("ewah_word_run_encoder_core_test failed");
      end
      $finish;
   end

endmodule

// File: ewah_word_run_encoder_core.f
hw/rtl/ewah_pkg.sv
hw/rtl/ewah_classify.sv
hw/rtl/ewah_group.sv
hw/rtl/ewah_obuf.sv
hw/rtl/ewah_word_run_encoder_core.sv
verif/ewah_word_run_encoder_core_test.sv
